### design/abb_pkg.sv
// Shared types, constants and helper functions for the alpha blend blitter.
// Used by every module of the block and by its port checker.
// Depends on nothing.
package abb_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 16;
    localparam int unsigned PIX_W           = 32;
    localparam int unsigned POS_W           = 16;
    localparam int unsigned CFG_W           = 16;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned SHIFTS_W        = 15;
    localparam int unsigned SIZES_W         = 12;
    localparam int unsigned LANES           = 3;
    localparam int unsigned RECIP_W         = 25;
    localparam int unsigned RECIP_SHIFT     = 24;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned QPTR_W          = 1;
    localparam int unsigned QCNT_W          = 2;

    localparam logic [7:0]  ALPHA_MAX = 8'hFF;
    localparam logic [15:0] FULL_SCALE = 16'd255;
    // floor(2^24 / 255), used to divide the blend sum by 255.
    localparam logic [16:0] RECIP_255 = 17'd65793;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X         = 3'd0,
        REG_DEST_Y         = 3'd1,
        REG_BLIT_WIDTH     = 3'd2,
        REG_BLIT_HEIGHT    = 3'd3,
        REG_SCREEN_WIDTH   = 3'd4,
        REG_SCREEN_HEIGHT  = 3'd5,
        REG_CHANNEL_SHIFTS = 3'd6,
        REG_CHANNEL_SIZES  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [15:0]         dest_x;
        logic [15:0]         dest_y;
        logic [15:0]         blit_width;
        logic [15:0]         blit_height;
        logic [15:0]         screen_width;
        logic [15:0]         screen_height;
        logic [SHIFTS_W-1:0] channel_shifts;
        logic [SIZES_W-1:0]  channel_sizes;
    } abb_cfg_t;

    localparam abb_cfg_t CFG_RESET = '{
        dest_x:         16'd0,
        dest_y:         16'd0,
        blit_width:     16'd1,
        blit_height:    16'd1,
        screen_width:   16'd1024,
        screen_height:  16'd768,
        channel_shifts: 15'd16640,
        channel_sizes:  12'd2184
    };

    typedef struct packed {
        logic [PIX_W-1:0] source_pixel;
        logic [PIX_W-1:0] dest_pixel;
    } abb_in_t;

    typedef struct packed {
        logic             write_enable;
        logic [POS_W-1:0] pixel_x;
        logic [POS_W-1:0] pixel_y;
        logic [PIX_W-1:0] blended_pixel;
        logic             last_pixel;
    } abb_out_t;

    // Classification made by the front end; coordinates are already zero when
    // the pixel is not written.
    typedef struct packed {
        logic             we;
        logic             last;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
    } abb_meta_t;

    typedef struct packed {
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        abb_meta_t        meta;
    } abb_item_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } abb_qstat_t;

    // Lane 0 is red, lane 1 green, lane 2 blue.
    function automatic logic [4:0] lane_shift(input logic [SHIFTS_W-1:0] shifts,
                                              input int lane);
        return shifts[5*(2-lane) +: 5];
    endfunction

    // A size of zero acts as one bit, anything above eight as eight bits.
    function automatic logic [3:0] lane_size(input logic [SIZES_W-1:0] sizes,
                                             input int lane);
        logic [3:0] s;
        s = sizes[4*(2-lane) +: 4];
        if (s == 4'd0) begin
            return 4'd1;
        end
        if (s > 4'd8) begin
            return 4'd8;
        end
        return s;
    endfunction

    function automatic logic [7:0] lane_src(input logic [PIX_W-1:0] src, input int lane);
        return src[8*(2-lane) +: 8];
    endfunction

    // Largest channel code for a clamped size of 1 to 8 bits.
    function automatic logic [7:0] size_mask(input logic [3:0] size);
        logic [8:0] full;
        full = (9'd1 << size) - 9'd1;
        return full[7:0];
    endfunction

    // floor(2^24 / (2^size - 1)) for a clamped size.
    function automatic logic [RECIP_W-1:0] size_recip(input logic [3:0] size);
        logic [RECIP_W-1:0] r;
        unique case (size)
            4'd1:    r = 25'd16777216;
            4'd2:    r = 25'd5592405;
            4'd3:    r = 25'd2396745;
            4'd4:    r = 25'd1118481;
            4'd5:    r = 25'd541200;
            4'd6:    r = 25'd266305;
            4'd7:    r = 25'd132104;
            default: r = 25'd65793;
        endcase
        return r;
    endfunction

endpackage

### design/abb_front.sv
// Front end of the alpha blend blitter: walks the blit rectangle, clips each
// pixel against the screen and pushes the classified item into the queue.
// Depends on abb_pkg.
module abb_front #(
    parameter int unsigned COORD_WIDTH = abb_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  abb_pkg::abb_cfg_t  cfg,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  abb_pkg::abb_in_t   pix,
    input  abb_pkg::abb_qstat_t qstat,
    output logic               push,
    output abb_pkg::abb_item_t item
);
    import abb_pkg::*;

    // Sums are one bit wider than the widest operand so they never wrap.
    localparam int unsigned SW = ((COORD_WIDTH > POS_W) ? COORD_WIDTH : POS_W) + 1;

    logic [COORD_WIDTH-1:0] column_count_reg, column_count_next;
    logic [COORD_WIDTH-1:0] row_count_reg, row_count_next;
    logic [SW-1:0]          tx, ty, wlim, hlim;
    logic                   col_end, row_end, on_screen;
    logic [7:0]             alpha;

    always_comb begin
        alpha = pix.source_pixel[31:24];
        tx    = SW'(cfg.dest_x) + SW'(column_count_reg);
        ty    = SW'(cfg.dest_y) + SW'(row_count_reg);
        wlim  = (cfg.blit_width == '0) ? '0 : SW'(cfg.blit_width) - SW'(1);
        hlim  = (cfg.blit_height == '0) ? '0 : SW'(cfg.blit_height) - SW'(1);

        col_end   = SW'(column_count_reg) >= wlim;
        row_end   = SW'(row_count_reg) >= hlim;
        on_screen = (tx < SW'(cfg.screen_width)) && (ty < SW'(cfg.screen_height))
                    && (alpha != '0);

        pix_ready      = !qstat.full;
        push           = pix_valid && !qstat.full;
        item.src       = pix.source_pixel;
        item.dst       = pix.dest_pixel;
        item.meta.we   = on_screen;
        item.meta.last = col_end && row_end;
        item.meta.px   = on_screen ? tx[POS_W-1:0] : '0;
        item.meta.py   = on_screen ? ty[POS_W-1:0] : '0;

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (push) begin
            if (col_end) begin
                column_count_next = '0;
                row_count_next    = row_end ? '0 : row_count_reg + COORD_WIDTH'(1);
            end else begin
                column_count_next = column_count_reg + COORD_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

### design/abb_queue.sv
// Two-entry queue between the front end and the blend pipeline.
// Depends on abb_pkg.
module abb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  abb_pkg::abb_item_t  item,
    input  logic                pop,
    output abb_pkg::abb_qstat_t qstat,
    output abb_pkg::abb_item_t  head
);
    import abb_pkg::*;

    abb_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb begin
        qstat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        qstat.not_empty = (count_reg != '0);
        head            = entry_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### design/abb_back.sv
// Back end of the alpha blend blitter: a stalling pipeline that unpacks the
// destination, expands it to 8 bits, blends, and repacks into the output register.
// Depends on abb_pkg.
module abb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  abb_pkg::abb_cfg_t   cfg,
    input  abb_pkg::abb_qstat_t qstat,
    input  abb_pkg::abb_item_t  head,
    output logic                pop,
    output logic                wr_valid,
    input  logic                wr_ready,
    output abb_pkg::abb_out_t   wr
);
    import abb_pkg::*;

    logic en;

    // Per-lane format from the configuration, which the user must keep stable while busy; unenforced.
    logic [4:0] sh [LANES];
    logic [3:0] sz [LANES];
    logic [7:0] m  [LANES];

    // Stage 1: unpacked channel scaled by 255.
    logic [15:0] s1_x [LANES];
    logic [15:0] s1_x_reg [LANES];
    logic [7:0]  s1_src_reg [LANES];
    logic [7:0]  s1_a_reg;
    abb_meta_t   s1_meta_reg;
    logic        s1_v_reg;

    // Stage 2: estimate of the expanded channel, possibly one short.
    logic [40:0] s2_p [LANES];
    logic [7:0]  s2_q_reg [LANES];
    logic [15:0] s2_x_reg [LANES];
    logic [7:0]  s2_src_reg [LANES];
    logic [7:0]  s2_a_reg;
    abb_meta_t   s2_meta_reg;
    logic        s2_v_reg;

    // Stage 3: estimate times the divisor, for the correction.
    logic [15:0] s3_t_reg [LANES];
    logic [7:0]  s3_q_reg [LANES];
    logic [15:0] s3_x_reg [LANES];
    logic [7:0]  s3_src_reg [LANES];
    logic [7:0]  s3_a_reg;
    abb_meta_t   s3_meta_reg;
    logic        s3_v_reg;

    // Stage 4: corrected destination channel and the weighted blend sum.
    logic [15:0] s4_r [LANES];
    logic [7:0]  s4_old [LANES];
    logic [15:0] s4_y_reg [LANES];
    abb_meta_t   s4_meta_reg;
    logic        s4_v_reg;

    // Stage 5: estimate of the blend sum divided by 255.
    logic [32:0] s5_p [LANES];
    logic [15:0] s5_y_reg [LANES];
    logic [7:0]  s5_q_reg [LANES];
    abb_meta_t   s5_meta_reg;
    logic        s5_v_reg;

    // Output stage: correction, top bits, placement.
    logic [15:0] o_r [LANES];
    logic [7:0]  o_mix [LANES];
    logic [7:0]  o_top [LANES];
    logic [PIX_W-1:0] o_pix;
    abb_out_t    wr_next;
    abb_out_t    wr_reg;
    logic        wr_valid_reg;

    always_comb begin
        en  = !wr_valid_reg || wr_ready;
        pop = en && qstat.not_empty;

        o_pix = '0;
        for (int c = 0; c < LANES; c++) begin
            sh[c] = lane_shift(cfg.channel_shifts, c);
            sz[c] = lane_size(cfg.channel_sizes, c);
            m[c]  = size_mask(sz[c]);

            begin
                logic [7:0] raw;
                raw     = 8'(head.dst >> sh[c]) & m[c];
                s1_x[c] = {raw, 8'h00} - {8'h00, raw};
            end

            s2_p[c] = 41'(s1_x_reg[c]) * 41'(size_recip(sz[c]));

            s4_r[c]   = s3_x_reg[c] - s3_t_reg[c];
            s4_old[c] = (s4_r[c] >= {8'h00, m[c]}) ? s3_q_reg[c] + 8'd1 : s3_q_reg[c];

            s5_p[c] = 33'(s4_y_reg[c]) * 33'(RECIP_255);

            o_r[c]   = s5_y_reg[c] - ({s5_q_reg[c], 8'h00} - {8'h00, s5_q_reg[c]});
            o_mix[c] = (o_r[c] >= FULL_SCALE) ? s5_q_reg[c] + 8'd1 : s5_q_reg[c];
            o_top[c] = o_mix[c] >> (4'd8 - sz[c]);
            o_pix    = o_pix | (PIX_W'(o_top[c]) << sh[c]);
        end

        wr_next.write_enable  = s5_meta_reg.we;
        wr_next.pixel_x       = s5_meta_reg.px;
        wr_next.pixel_y       = s5_meta_reg.py;
        wr_next.blended_pixel = s5_meta_reg.we ? o_pix : '0;
        wr_next.last_pixel    = s5_meta_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            s5_v_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg     <= pop;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            s4_v_reg     <= s3_v_reg;
            s5_v_reg     <= s4_v_reg;
            wr_valid_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_a_reg    <= head.src[31:24];
            s1_meta_reg <= head.meta;
            s2_a_reg    <= s1_a_reg;
            s2_meta_reg <= s1_meta_reg;
            s3_a_reg    <= s2_a_reg;
            s3_meta_reg <= s2_meta_reg;
            s4_meta_reg <= s3_meta_reg;
            s5_meta_reg <= s4_meta_reg;
            wr_reg      <= wr_next;
            for (int c = 0; c < LANES; c++) begin
                s1_x_reg[c]   <= s1_x[c];
                s1_src_reg[c] <= lane_src(head.src, c);
                s2_q_reg[c]   <= s2_p[c][RECIP_SHIFT +: 8];
                s2_x_reg[c]   <= s1_x_reg[c];
                s2_src_reg[c] <= s1_src_reg[c];
                s3_t_reg[c]   <= 16'(s2_q_reg[c]) * 16'(m[c]);
                s3_q_reg[c]   <= s2_q_reg[c];
                s3_x_reg[c]   <= s2_x_reg[c];
                s3_src_reg[c] <= s2_src_reg[c];
                s4_y_reg[c]   <= 16'(s3_src_reg[c]) * 16'(s3_a_reg)
                               + 16'(s4_old[c]) * 16'(ALPHA_MAX - s3_a_reg);
                s5_y_reg[c]   <= s4_y_reg[c];
                s5_q_reg[c]   <= s5_p[c][RECIP_SHIFT +: 8];
            end
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

### design/alpha_blend_blitter_core.sv
// Top level of the alpha blend blitter: configuration registers, front end,
// queue and blend pipeline. Depends on abb_pkg, abb_front, abb_queue and abb_back.
//
// The blitter takes one ARGB8888 source pixel per item, in row-major order over
// the configured rectangle, together with the destination pixel now held at that
// screen spot, and returns one result item per input item. A pixel that falls
// off screen or has zero alpha comes back with write_enable low and zero
// coordinates and colour; otherwise the destination's red, green and blue are
// unpacked with the configured shifts and sizes, expanded to 8 bits, blended
// with the source alpha and repacked into the framebuffer's native format. The
// last pixel of the rectangle is flagged. The block sustains one item per clock
// while the output does not stall: the front end classifies each item in the cycle
// it is accepted and places it in a two-entry queue, and the six-stage blend
// pipeline behind it takes one item a cycle when nothing stalls. A stall at
// the output holds the whole pipeline while the queue
// soaks up the front end. Configuration registers are written with cfg_we and
// should only be changed while no item is in flight; the rectangle counters are
// never touched by a register write and return to the top-left corner after
// the last pixel.
module alpha_blend_blitter_core #(
    parameter int unsigned COORD_WIDTH = abb_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_ready,
    input  abb_pkg::abb_in_t                   pix,
    output logic                               wr_valid,
    input  logic                               wr_ready,
    output abb_pkg::abb_out_t                  wr,
    input  logic                               cfg_we,
    input  logic [abb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abb_pkg::CFG_W-1:0]          cfg_data
);
    import abb_pkg::*;

    abb_cfg_t   cfg_reg, cfg_next;
    abb_qstat_t qstat;
    abb_item_t  item, head;
    logic       push, pop;

    // Register file: every index of the three-bit field names a register.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_DEST_X:         cfg_next.dest_x         = cfg_data;
                REG_DEST_Y:         cfg_next.dest_y         = cfg_data;
                REG_BLIT_WIDTH:     cfg_next.blit_width     = cfg_data;
                REG_BLIT_HEIGHT:    cfg_next.blit_height    = cfg_data;
                REG_SCREEN_WIDTH:   cfg_next.screen_width   = cfg_data;
                REG_SCREEN_HEIGHT:  cfg_next.screen_height  = cfg_data;
                REG_CHANNEL_SHIFTS: cfg_next.channel_shifts = cfg_data[SHIFTS_W-1:0];
                REG_CHANNEL_SIZES:  cfg_next.channel_sizes  = cfg_data[SIZES_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end walks the rectangle and decides whether each pixel is written.
    abb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .qstat     (qstat),
        .push      (push),
        .item      (item)
    );

    // The queue lets the front end keep accepting while the pipeline is held.
    abb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    // The blend pipeline ends in the output register.
    abb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr       (wr)
    );

endmodule

### design/abb_checker.sv
// Port-level checker for the alpha blend blitter and the bind that attaches it.
// Depends on abb_pkg and alpha_blend_blitter_core.
module abb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_ready,
    input logic              wr_valid,
    input logic              wr_ready,
    input abb_pkg::abb_out_t wr,
    input logic              cfg_we
);
    import abb_pkg::*;

    // Queue, five pipeline stages and the output register.
    localparam logic [3:0] MAX_INFLIGHT = 4'd8;

    logic [3:0] inflight_reg, inflight_next;
    logic       in_acc, out_acc;

    always_comb begin
        in_acc        = pix_valid && pix_ready;
        out_acc       = wr_valid && wr_ready;
        inflight_next = inflight_reg + 4'(in_acc) - 4'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(wr))
        else $error("result changed or dropped while stalled");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr.write_enable |->
            wr.pixel_x == '0 && wr.pixel_y == '0 && wr.blended_pixel == '0)
        else $error("skipped pixel carries non-zero position or colour");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid |-> inflight_reg != '0)
        else $error("result offered with no item in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= MAX_INFLIGHT)
        else $error("more items in flight than the block can hold");

    // Registers may only change while the block holds no item.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> inflight_reg == '0)
        else $error("configuration written while items are in flight");

endmodule

bind alpha_blend_blitter_core abb_checker u_abb_checker (.*);

### tb/abb_blend_checker.sv
// Port checker for alpha_blend_blitter_core: mirrors the register file and the
// rectangle counters, predicts every write item and compares it with the output.
// Depends on abb_pkg for the port types and register names.
module abb_blend_checker
    import abb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    input  logic                 pix_ready,
    input  abb_in_t              pix,
    input  logic                 wr_valid,
    input  logic                 wr_ready,
    input  abb_out_t             wr,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    abb_cfg_t    regs;
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    abb_out_t    pending_writes[$];

    function automatic logic [15:0] rect_limit(input logic [15:0] n);
        return (n == 16'd0) ? 16'd0 : n - 16'd1;
    endfunction

    // Expands one destination channel to 8 bits, blends it with the source
    // channel and returns its bits placed back at the channel's position.
    function automatic logic [31:0] blend_lane(input logic [31:0] dst,
                                               input logic [4:0]  shift,
                                               input logic [3:0]  size_code,
                                               input logic [7:0]  src8,
                                               input logic [7:0]  alpha);
        int unsigned bits;
        int unsigned maxv;
        int unsigned raw;
        int unsigned old8;
        int unsigned s;
        int unsigned a;
        int unsigned mixed;
        int unsigned kept;
        logic [63:0] placed;
        bits   = (size_code == 4'd0) ? 1 : (size_code > 4'd8) ? 8 : size_code;
        maxv   = (32'd1 << bits) - 32'd1;
        raw    = (dst >> shift) & maxv;
        old8   = (raw * 255) / maxv;
        s      = src8;
        a      = alpha;
        mixed  = (s * a + old8 * (255 - a)) / 255;
        kept   = mixed >> (8 - bits);
        placed = 64'(kept) << shift;
        return placed[31:0];
    endfunction

    function automatic abb_out_t predict_write(input abb_in_t p);
        abb_out_t    o;
        logic [16:0] tx;
        logic [16:0] ty;
        logic [7:0]  alpha;
        alpha = p.source_pixel[31:24];
        tx    = {1'b0, regs.dest_x} + {1'b0, col_pos};
        ty    = {1'b0, regs.dest_y} + {1'b0, row_pos};
        o     = '0;
        o.last_pixel = (col_pos >= rect_limit(regs.blit_width)) &&
                       (row_pos >= rect_limit(regs.blit_height));
        o.write_enable = (tx < {1'b0, regs.screen_width}) &&
                         (ty < {1'b0, regs.screen_height}) && (alpha != 8'd0);
        if (o.write_enable) begin
            o.pixel_x = tx[15:0];
            o.pixel_y = ty[15:0];
            o.blended_pixel =
                blend_lane(p.dest_pixel, regs.channel_shifts[14:10],
                           regs.channel_sizes[11:8], p.source_pixel[23:16], alpha) |
                blend_lane(p.dest_pixel, regs.channel_shifts[9:5],
                           regs.channel_sizes[7:4], p.source_pixel[15:8], alpha) |
                blend_lane(p.dest_pixel, regs.channel_shifts[4:0],
                           regs.channel_sizes[3:0], p.source_pixel[7:0], alpha);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] write item mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        abb_out_t want;
        if (!rst_n) begin
            regs    = CFG_RESET;
            col_pos = '0;
            row_pos = '0;
            pending_writes.delete();
            errors      = 0;
            outstanding = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_e'(cfg_index))
                    REG_DEST_X:         regs.dest_x = cfg_data;
                    REG_DEST_Y:         regs.dest_y = cfg_data;
                    REG_BLIT_WIDTH:     regs.blit_width = cfg_data;
                    REG_BLIT_HEIGHT:    regs.blit_height = cfg_data;
                    REG_SCREEN_WIDTH:   regs.screen_width = cfg_data;
                    REG_SCREEN_HEIGHT:  regs.screen_height = cfg_data;
                    REG_CHANNEL_SHIFTS: regs.channel_shifts = cfg_data[SHIFTS_W-1:0];
                    REG_CHANNEL_SIZES:  regs.channel_sizes = cfg_data[SIZES_W-1:0];
                    default: ;
                endcase
            end

            // Compare before taking a new item, so an early output can never
            // be matched against the item that arrives in the same cycle.
            if (wr_valid && wr_ready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %h", wr));
                end else begin
                    want = pending_writes.pop_front();
                    check_field("write_enable", 32'(wr.write_enable), 32'(want.write_enable));
                    check_field("pixel_x", 32'(wr.pixel_x), 32'(want.pixel_x));
                    check_field("pixel_y", 32'(wr.pixel_y), 32'(want.pixel_y));
                    check_field("blended_pixel", wr.blended_pixel, want.blended_pixel);
                    check_field("last_pixel", 32'(wr.last_pixel), 32'(want.last_pixel));
                end
            end

            if (pix_valid && pix_ready) begin
                pending_writes.push_back(predict_write(pix));
                if (col_pos >= rect_limit(regs.blit_width)) begin
                    col_pos = '0;
                    row_pos = (row_pos >= rect_limit(regs.blit_height)) ? '0
                                                                         : row_pos + 16'd1;
                end else begin
                    col_pos = col_pos + 16'd1;
                end
            end
            outstanding = pending_writes.size();
        end
    end

endmodule

### tb/tb_alpha_blend_blitter_core.sv
// Testbench top for alpha_blend_blitter_core: clock, reset, register programming,
// pixel stimulus, output back-pressure and the final verdict.
// Depends on abb_pkg, the block itself and abb_blend_checker.
module tb_alpha_blend_blitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import abb_pkg::*;

    localparam int TARGET_ITEMS = 1150;
    // Cycles the output is held off in a pressure phase: far more than the
    // queue and the blend pipeline can absorb, so the input must stall.
    localparam int LONG_HOLD    = 80;
    // Settling time after the last result, well beyond the six-stage pipeline.
    localparam int SETTLE       = 12;
    // Cycles with no item moving on either side before the run is abandoned.
    localparam int IDLE_LIMIT   = 1000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    abb_in_t              pix = '0;
    logic                 wr_valid;
    logic                 wr_ready = 1'b0;
    abb_out_t             wr;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int errors;
    int outstanding;
    int items_sent = 0;
    int idle_cycles = 0;
    // The stimulus raises hold_requests; the output process answers each one
    // with a long hold and counts it in holds_started.
    int hold_requests = 0;
    int holds_started = 0;

    always #6 clk = ~clk;

    alpha_blend_blitter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    abb_blend_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix),
        .wr_valid    (wr_valid),
        .wr_ready    (wr_ready),
        .wr          (wr),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // All tasks below are entered at a falling edge and return at one.

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Every register is written on each reprogramming, so the whole register
    // file is exercised many times over the run.
    task automatic program_regs(input abb_cfg_t c);
        write_reg(REG_DEST_X, c.dest_x);
        write_reg(REG_DEST_Y, c.dest_y);
        write_reg(REG_BLIT_WIDTH, c.blit_width);
        write_reg(REG_BLIT_HEIGHT, c.blit_height);
        write_reg(REG_SCREEN_WIDTH, c.screen_width);
        write_reg(REG_SCREEN_HEIGHT, c.screen_height);
        write_reg(REG_CHANNEL_SHIFTS, CFG_W'(c.channel_shifts));
        write_reg(REG_CHANNEL_SIZES, CFG_W'(c.channel_sizes));
        cfg_we <= 1'b0;
    endtask

    // Offers one item after an optional gap and waits for it to be taken.
    // With no gap, valid simply stays high from the previous item.
    task automatic push_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input int gap);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.source_pixel <= src;
        pix.dest_pixel   <= dst;
        pix_valid        <= 1'b1;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Ends a phase: no register may change until every write item is back
    // and the pipeline has had time to empty.
    task automatic drain;
        pix_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Alpha is pushed towards its two extremes, since zero suppresses the
    // write and full alpha ignores the destination entirely.
    function automatic logic [31:0] rand_source();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(0, 7))
            0:       p[31:24] = 8'h00;
            1:       p[31:24] = 8'hFF;
            2:       p[31:24] = 8'h01;
            default: ;
        endcase
        return p;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 19);
        if (burst || r < 10) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_origin();
        logic [15:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    return 16'hFFFF - 16'($urandom_range(0, 3));
            2:       return v;
            default: return 16'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic [15:0] rand_extent();
        case ($urandom_range(0, 19))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [15:0] rand_screen();
        logic [15:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return v;
            default: return 16'($urandom_range(4, 16));
        endcase
    endfunction

    // Mostly small rectangles near small screens so that clipping, the
    // rectangle end and the last-pixel flag all come up often. Channel layouts
    // are the default 8:8:8, RGB565, or anything the fields can hold.
    function automatic abb_cfg_t rand_cfg();
        abb_cfg_t c;
        logic [31:0] r;
        r = $urandom;
        c.dest_x        = rand_origin();
        c.dest_y        = rand_origin();
        c.blit_width    = rand_extent();
        c.blit_height   = rand_extent();
        c.screen_width  = rand_screen();
        c.screen_height = rand_screen();
        case ($urandom_range(0, 5))
            0: begin
                c.channel_shifts = CFG_RESET.channel_shifts;
                c.channel_sizes  = CFG_RESET.channel_sizes;
            end
            1: begin
                c.channel_shifts = {5'd11, 5'd5, 5'd0};
                c.channel_sizes  = {4'd5, 4'd6, 4'd5};
            end
            default: begin
                c.channel_shifts = r[14:0];
                c.channel_sizes  = r[26:15];
            end
        endcase
        return c;
    endfunction

    // Output side: random runs of ready high and low, including long open
    // stretches, and the long holds that the stimulus asks for.
    initial begin
        bit level;
        int run_left;
        int r;
        level = 1'b0;
        run_left = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (holds_started < hold_requests) begin
                holds_started++;
                wr_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 19);
                    if (r < 12) begin
                        level = 1'b1;
                        run_left = $urandom_range(1, 6);
                    end else if (r < 17) begin
                        level = 1'b0;
                        run_left = $urandom_range(1, 4);
                    end else if (r < 18) begin
                        level = 1'b0;
                        run_left = $urandom_range(10, 30);
                    end else begin
                        level = 1'b1;
                        run_left = $urandom_range(40, 120);
                    end
                end
                wr_ready <= level;
                run_left--;
            end
        end
    end

    // Watchdog: a run in which no item moves for too long has hung.
    always @(posedge clk) begin
        if ((pix_valid && pix_ready) || (wr_valid && wr_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("** alpha_blend_blitter_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        abb_cfg_t c;
        int phase_no;
        int count;
        int area;
        bit burst;
        logic [31:0] colour;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset layout, single-pixel rectangle: every item is the last one.
        // Alpha zero, full, one and a midpoint against both colour extremes.
        push_pixel(32'h00FFFFFF, 32'hFFFFFFFF, 0);
        push_pixel(32'hFFFFFFFF, 32'h00000000, 0);
        push_pixel(32'hFF000000, 32'hFFFFFFFF, 1);
        push_pixel(32'h01FFFFFF, 32'h00000000, 0);
        push_pixel(32'h80123456, 32'h89ABCDEF, 2);
        push_pixel(32'hFE00FF00, 32'hFFFFFFFF, 0);
        drain();

        // A 3x3 rectangle hanging over the bottom-right corner of the default
        // screen: the right column and the bottom row are clipped.
        c = CFG_RESET;
        c.dest_x      = 16'd1022;
        c.dest_y      = 16'd766;
        c.blit_width  = 16'd3;
        c.blit_height = 16'd3;
        program_regs(c);
        repeat (9) begin
            colour = $urandom;
            push_pixel(32'hFF000000 | (colour & 32'h00FFFFFF), $urandom, 0);
        end
        drain();

        // Origin at the top of the coordinate range: the screen position must
        // not wrap, so nothing is written. A zero-sized rectangle acts as 1x1.
        // Channel sizes of zero and above eight, and a shift of 31.
        c.dest_x         = 16'hFFFF;
        c.dest_y         = 16'hFFFF;
        c.blit_width     = 16'd0;
        c.blit_height    = 16'd0;
        c.screen_width   = 16'hFFFF;
        c.screen_height  = 16'hFFFF;
        c.channel_shifts = {5'd31, 5'd20, 5'd0};
        c.channel_sizes  = {4'd0, 4'hF, 4'd5};
        program_regs(c);
        repeat (4) push_pixel(32'hFF000000 | $urandom_range(0, 32'hFFFFFF), $urandom, 0);
        drain();

        // One-pixel screen and a two-pixel row; every shift and size field at
        // its maximum, so channels pile up at the top of the word.
        c.dest_x         = 16'd0;
        c.dest_y         = 16'd0;
        c.blit_width     = 16'd2;
        c.blit_height    = 16'd1;
        c.screen_width   = 16'd1;
        c.screen_height  = 16'd1;
        c.channel_shifts = 15'h7FFF;
        c.channel_sizes  = 12'hFFF;
        program_regs(c);
        repeat (4) push_pixel(32'h7F000000 | $urandom_range(0, 32'hFFFFFF), $urandom, 0);
        drain();

        // Random phases. Registers change between phases while the rectangle
        // counters carry on, so a shrunk rectangle leaves counts past their
        // limit. Some phases send whole rectangles, others stop anywhere.
        phase_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            c = rand_cfg();
            program_regs(c);
            area = ((c.blit_width == 0) ? 1 : c.blit_width) *
                   ((c.blit_height == 0) ? 1 : c.blit_height);
            if (area <= 64 && $urandom_range(0, 1) == 1) begin
                count = area * $urandom_range(1, 3);
            end else begin
                count = $urandom_range(1, 40);
            end
            burst = ($urandom_range(0, 3) == 0);

            // Now and then the output stops for a long stretch while items
            // keep coming back to back, filling the queue and the pipeline.
            if (phase_no % 12 == 3) begin
                hold_requests++;
                while (holds_started < hold_requests) @(negedge clk);
                burst = 1'b1;
                count = 40;
            end

            repeat (count) push_pixel(rand_source(), $urandom, pick_gap(burst));
            drain();
            phase_no++;
        end

        if (errors == 0 && outstanding == 0) begin
            $display("** alpha_blend_blitter_core: PASSED **");
        end else begin
            $display("** alpha_blend_blitter_core: FAILED **");
        end
        $finish;
    end

endmodule
